### sv/nps_pkg.sv
package nps_pkg;

  localparam int COORD_W    = 16;
  localparam int IDX_W      = 6;
  localparam int DIST_W     = 34;
  localparam int SQ_W       = 32;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 40;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [DIST_W-1:0]         dist_t;

  // packed x in the low bits, as stored in the point table
  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } point_t;

  localparam int POINT_W = $bits(point_t);

  // control that travels down the distance pipeline beside each entry
  typedef struct packed {
    logic valid;
    logic last;
  } tag_t;

endpackage

### sv/nearest_point_search.sv
// Nearest point search over a table of 3-D points.
//
// Input stream (in_*): in_tuser is the function, 0 = write a point, 1 = query.
//   A write stores x, y, z at entry_index (ignored when entry_index >= N_POINTS)
//   and yields no result word.
// Result stream (out_*): one word per query, the index of the nearest stored
//   point (lowest index on ties) and its squared distance.
// A query scans the table one entry per cycle through the RAM read port and a
//   three-stage distance pipeline; after the last entry has been compared the
//   result word is loaded into the output register and the sequencer returns
//   to idle; in_tready stays low while the query is in progress.
// Every entry a query may reach must be written first; the table has no reset.
// If the receiver stalls, the finished result waits in the output register;
//   writes are still taken, a new query is accepted but its result waits
//   until the previous word has been taken, with in_tready low until then.
// Reset clears the sequencer and the output valid; table contents are kept.
module nearest_point_search #(
  parameter int N_POINTS = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // entry_index[5:0], pos_x[21:6], pos_y[37:22], pos_z[53:38], zero[55:54]
  input  logic [nps_pkg::IN_DATA_W-1:0]      in_tdata,
  // func[0]
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // nearest_index[5:0], nearest_dist_sq[39:6]
  output logic [nps_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import nps_pkg::*;

  localparam int AW = $clog2(N_POINTS);
  localparam int CW = $clog2(N_POINTS + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] ret_r, ret_nxt;
  logic [AW-1:0] best_i_r, best_i_nxt;
  dist_t         best_d_r, best_d_nxt;
  point_t        q_r, q_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  tag_t          tag_issue, tag_ram_r, tag_dist;
  dist_t         scan_dist;
  point_t        in_pt, ram_pt;
  logic [POINT_W-1:0] ram_rdata;
  logic [IDX_W-1:0]   in_entry;
  logic          in_acc, ram_we, in_range, issuing;

  assign in_entry = in_tdata[IDX_W-1:0];
  assign in_pt    = point_t'(in_tdata[IDX_W +: POINT_W]);
  assign in_acc   = in_tvalid && in_tready;
  assign in_range = 32'(in_entry) < 32'(N_POINTS);
  assign ram_we   = in_acc && (in_tuser == FUNC_WRITE) && in_range;
  assign in_tready = (state_r == S_IDLE);

  assign issuing         = (state_r == S_SCAN) && (cnt_r != CW'(N_POINTS));
  assign tag_issue.valid = issuing;
  assign tag_issue.last  = (cnt_r == CW'(N_POINTS - 1));

  nps_ram #(
    .WIDTH(POINT_W),
    .DEPTH(N_POINTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(AW'(in_entry)),
    .wdata(in_pt),
    .raddr(cnt_r[AW-1:0]),
    .rdata(ram_rdata)
  );

  assign ram_pt = point_t'(ram_rdata);

  nps_dist u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .tag_in (tag_ram_r),
    .pt     (ram_pt),
    .query  (q_r),
    .tag_out(tag_dist),
    .dist_sq(scan_dist)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ret_nxt       = ret_r;
    best_i_nxt    = best_i_r;
    best_d_nxt    = best_d_r;
    q_nxt         = q_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_tuser == FUNC_QUERY)) begin
          q_nxt     = in_pt;
          cnt_nxt   = '0;
          ret_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (issuing) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (tag_dist.valid) begin
          // strict compare keeps the lowest index on ties
          if ((ret_r == '0) || (scan_dist < best_d_r)) begin
            best_d_nxt = scan_dist;
            best_i_nxt = ret_r;
          end
          ret_nxt = ret_r + 1'b1;
          if (tag_dist.last) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {best_d_r, IDX_W'(best_i_r)};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ret_r       <= '0;
      out_valid_r <= 1'b0;
      tag_ram_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ret_r       <= ret_nxt;
      out_valid_r <= out_valid_nxt;
      tag_ram_r   <= tag_issue;
    end
    best_i_r   <= best_i_nxt;
    best_d_r   <= best_d_nxt;
    q_r        <= q_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // distance results only come back while a scan is running
  a_dist_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tag_dist.valid |-> (state_r == S_SCAN))
    else $error("distance result outside a scan");

  // a result word appears only after the scan has finished
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result word raised outside the done state");

  // the read counter never runs past the table
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(N_POINTS))
    else $error("scan counter out of range");

  // table writes never overlap a scan
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_IDLE) && !tag_ram_r.valid)
    else $error("table written during a scan");

endmodule

### sv/nps_ram.sv
module nps_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/nps_dist.sv
module nps_dist (
  input  logic            clk,
  input  logic            rst_n,
  input  nps_pkg::tag_t   tag_in,
  input  nps_pkg::point_t pt,
  input  nps_pkg::point_t query,
  output nps_pkg::tag_t   tag_out,
  output nps_pkg::dist_t  dist_sq
);
  import nps_pkg::*;

  // stage 1: differences, stage 2: squares, stage 3: sum
  logic signed [COORD_W:0] dx_r, dy_r, dz_r;
  logic signed [COORD_W:0] dx_nxt, dy_nxt, dz_nxt;
  logic signed [2*COORD_W+1:0] px, py, pz;
  logic [SQ_W-1:0] sqx_r, sqy_r, sqz_r;
  dist_t sum_r, sum_nxt;
  tag_t  tag1_r, tag2_r, tag3_r;

  assign dx_nxt = $signed({pt.x[COORD_W-1], pt.x}) - $signed({query.x[COORD_W-1], query.x});
  assign dy_nxt = $signed({pt.y[COORD_W-1], pt.y}) - $signed({query.y[COORD_W-1], query.y});
  assign dz_nxt = $signed({pt.z[COORD_W-1], pt.z}) - $signed({query.z[COORD_W-1], query.z});

  assign px = dx_r * dx_r;
  assign py = dy_r * dy_r;
  assign pz = dz_r * dz_r;

  // each square is below 2^32, so the low bits carry it exactly
  assign sum_nxt = {2'b00, sqx_r} + {2'b00, sqy_r} + {2'b00, sqz_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
    end else begin
      tag1_r <= tag_in;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
    end
    dx_r  <= dx_nxt;
    dy_r  <= dy_nxt;
    dz_r  <= dz_nxt;
    sqx_r <= px[SQ_W-1:0];
    sqy_r <= py[SQ_W-1:0];
    sqz_r <= pz[SQ_W-1:0];
    sum_r <= sum_nxt;
  end

  assign tag_out = tag3_r;
  assign dist_sq = sum_r;

endmodule
